/* sv/pfc_ecn_ingress_accountant_defines.svh */
// ----------------------------------------------------------------------------
// pfc_ecn_ingress_accountant_defines.svh
// Assertion macros used by the ingress accountant datapath (peia_dp).
// ----------------------------------------------------------------------------
`ifndef PFC_ECN_INGRESS_ACCOUNTANT_DEFINES_SVH
`define PFC_ECN_INGRESS_ACCOUNTANT_DEFINES_SVH

`ifndef SYNTHESIS
`define PEIA_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("peia assertion failed");
`define PEIA_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("peia assertion failed");
`else
`define PEIA_ASSERT_IMP(label, clk, rst_n, pre, post)
`define PEIA_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif

`endif

/* sv/peia_pkg.sv */
// ----------------------------------------------------------------------------
// peia_pkg
// Types and constants for the PFC/ECN ingress buffer accountant.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package peia_pkg;

  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int SIZE_W      = 16;
  localparam int DRAW_W      = 31;
  localparam int PTIME_W     = 16;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  localparam logic [PTIME_W-1:0] PAUSE_QUANTA = 16'd1000;
  localparam logic [PTIME_W-1:0] RESUME_QUANTA = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_THR = 3'd0,
    REG_LOW_THR  = 3'd1,
    REG_ECN_MIN  = 3'd2,
    REG_ECN_MAX  = 3'd3,
    REG_BUF_LIM  = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    MODE_ARRIVAL   = 1'b0,
    MODE_DEPARTURE = 1'b1
  } pkt_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CALC = 2'd1,
    ST_EVAL = 2'd2,
    ST_DONE = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    logic load_in;
    logic calc;
    logic eval;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* sv/pfc_ecn_ingress_accountant.sv */
// ----------------------------------------------------------------------------
// pfc_ecn_ingress_accountant
// Lossless ingress buffer accountant with PFC pause hysteresis and
// RED-style ECN marking on departures.
//
//   port group   dir  content
//   s_axis       in   tuser: mode; tdata: pkt_size, random_draw
//   m_axis       out  tdata: send_pause, pause_time, ecn_mark, paused,
//                     overflow, occupancy
//   cfg          in   write enable, register index, 32-bit data
//
// A transaction runs through the steps accept, occupancy update, threshold
// compares with one 32x32 multiply, and result load into the output register.
// The next transaction is accepted the cycle after the result is loaded.
// A stalled m_axis holds the sequencer in its last step until the output
// register frees up. Reset is asynchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfc_ecn_ingress_accountant #(
  parameter int OCC_WIDTH = 32
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [peia_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire  [peia_pkg::CFG_W-1:0]           cfg_data_i,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [15:0] pkt_size, [46:16] random_draw, [47] zero
  input  wire  [peia_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [0] mode
  input  wire                                  s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // [0] send_pause, [16:1] pause_time, [17] ecn_mark, [18] paused,
  // [19] overflow, [51:20] occupancy, [55:52] zero
  output logic [peia_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import peia_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  logic               send_pause, ecn_mark, paused, overflow;
  logic [PTIME_W-1:0] pause_time;
  logic [CFG_W-1:0]   occupancy;

  peia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  peia_dp #(
    .OCC_WIDTH (OCC_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_mode_i    (s_axis_tuser),
    .in_size_i    (s_axis_tdata[SIZE_W-1:0]),
    .in_draw_i    (s_axis_tdata[SIZE_W+DRAW_W-1:SIZE_W]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .send_pause_o (send_pause),
    .pause_time_o (pause_time),
    .ecn_mark_o   (ecn_mark),
    .paused_o     (paused),
    .overflow_o   (overflow),
    .occupancy_o  (occupancy)
  );

  assign m_axis_tdata = {4'b0000, occupancy, overflow, paused, ecn_mark, pause_time,
                         send_pause};

endmodule

`default_nettype wire

/* sv/peia_ctrl.sv */
// ----------------------------------------------------------------------------
// peia_ctrl
// Sequencer: accept, update occupancy, evaluate thresholds, deliver result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module peia_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  peia_pkg::dp_sts_t  sts_i,
  output peia_pkg::dp_cmd_t  cmd_o
);
  import peia_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CALC;
      ST_CALC: state_d = ST_EVAL;
      ST_EVAL: state_d = ST_DONE;
      ST_DONE: if (sts_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_CALC: cmd_o.calc = 1'b1;
      ST_EVAL: cmd_o.eval = 1'b1;
      ST_DONE: cmd_o.finish = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* sv/peia_dp.sv */
// ----------------------------------------------------------------------------
// peia_dp
// Datapath: config registers, occupancy, threshold compares, ECN product
// compare and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pfc_ecn_ingress_accountant_defines.svh"

module peia_dp #(
  parameter int OCC_WIDTH = 32
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [peia_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [peia_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire                                in_mode_i,
  input  wire  [peia_pkg::SIZE_W-1:0]        in_size_i,
  input  wire  [peia_pkg::DRAW_W-1:0]        in_draw_i,
  input  peia_pkg::dp_cmd_t                  cmd_i,
  output peia_pkg::dp_sts_t                  sts_o,
  input  wire                                out_ready_i,
  output logic                               out_valid_o,
  output logic                               send_pause_o,
  output logic [peia_pkg::PTIME_W-1:0]       pause_time_o,
  output logic                               ecn_mark_o,
  output logic                               paused_o,
  output logic                               overflow_o,
  output logic [peia_pkg::CFG_W-1:0]         occupancy_o
);
  import peia_pkg::*;

  localparam int CMP_W = (OCC_WIDTH > CFG_W) ? OCC_WIDTH : CFG_W;
  localparam int PROD_W = 2 * CFG_W;
  localparam int SCL_W = CFG_W + DRAW_W;

  // configuration
  logic [CFG_W-1:0] high_q, low_q, min_q, max_q, lim_q, span_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q <= '1;
      low_q  <= '0;
      min_q  <= '0;
      max_q  <= '1;
      lim_q  <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HIGH_THR: high_q <= cfg_data_i;
        REG_LOW_THR:  low_q  <= cfg_data_i;
        REG_ECN_MIN:  min_q  <= cfg_data_i;
        REG_ECN_MAX:  max_q  <= cfg_data_i;
        REG_BUF_LIM:  lim_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    span_q <= max_q - min_q;
  end

  // captured transaction
  logic              mode_q;
  logic [SIZE_W-1:0] size_q;
  logic [DRAW_W-1:0] draw_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= in_mode_i;
      size_q <= in_size_i;
      draw_q <= in_draw_i;
    end
  end

  // occupancy update
  logic [OCC_WIDTH-1:0] occ_q, occ_d, size_ext;
  logic [OCC_WIDTH:0]   sum_w;
  logic                 sat_q;

  assign size_ext = OCC_WIDTH'(size_q);
  assign sum_w    = {1'b0, occ_q} + {1'b0, size_ext};

  always_comb begin
    if (mode_q == MODE_ARRIVAL) begin
      occ_d = sum_w[OCC_WIDTH] ? '1 : sum_w[OCC_WIDTH-1:0];
    end else if (size_ext >= occ_q) begin
      occ_d = '0;
    end else begin
      occ_d = occ_q - size_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (cmd_i.calc) begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      sat_q <= (mode_q == MODE_ARRIVAL) && sum_w[OCC_WIDTH];
    end
  end

  // threshold compares and ECN products
  logic [CMP_W-1:0]  occ_ext, diff_w;
  logic [CFG_W-1:0]  draw1_w, d_w;
  logic [PROD_W-1:0] prod_w, prod_q;
  logic [SCL_W-1:0]  scaled_w, scaled_q;
  logic gt_high_q, gt_lim_q, lt_low_q, gt_max_q, gt_min_q;

  assign occ_ext  = CMP_W'(occ_q);
  assign diff_w   = occ_ext - CMP_W'(min_q);
  assign d_w      = diff_w[CFG_W-1:0];
  assign draw1_w  = {1'b0, draw_q} + CFG_W'(1);
  assign prod_w   = draw1_w * span_q;
  // 0x7FFFFFFF * d as (d << 31) - d
  assign scaled_w = {d_w, {DRAW_W{1'b0}}} - SCL_W'(d_w);

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      gt_high_q <= occ_ext > CMP_W'(high_q);
      gt_lim_q  <= occ_ext > CMP_W'(lim_q);
      lt_low_q  <= occ_ext < CMP_W'(low_q);
      gt_max_q  <= occ_ext > CMP_W'(max_q);
      gt_min_q  <= occ_ext > CMP_W'(min_q);
      prod_q    <= prod_w;
      scaled_q  <= scaled_w;
    end
  end

  // result
  logic               paused_q, paused_d;
  logic               send_d, mark_d, ovf_d;
  logic [PTIME_W-1:0] ptime_d;

  // draw < floor(S*d/span)  <=>  (draw+1)*span <= S*d
  always_comb begin
    if (mode_q == MODE_ARRIVAL) begin
      send_d   = gt_high_q && !paused_q;
      paused_d = paused_q || gt_high_q;
      ptime_d  = send_d ? PAUSE_QUANTA : RESUME_QUANTA;
      mark_d   = 1'b0;
      ovf_d    = sat_q || gt_lim_q;
    end else begin
      send_d   = lt_low_q && paused_q;
      paused_d = paused_q && !lt_low_q;
      ptime_d  = RESUME_QUANTA;
      mark_d   = gt_max_q || (gt_min_q && (prod_q <= {1'b0, scaled_q}));
      ovf_d    = 1'b0;
    end
  end

  logic out_valid_q;
  logic send_q, mark_q, ovf_q, opaused_q;
  logic [PTIME_W-1:0] ptime_q;
  logic [CFG_W-1:0]   oocc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paused_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        paused_q    <= paused_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      send_q    <= send_d;
      ptime_q   <= ptime_d;
      mark_q    <= mark_d;
      opaused_q <= paused_d;
      ovf_q     <= ovf_d;
      oocc_q    <= occ_ext[CFG_W-1:0];
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign send_pause_o   = send_q;
  assign pause_time_o   = ptime_q;
  assign ecn_mark_o     = mark_q;
  assign paused_o       = opaused_q;
  assign overflow_o     = ovf_q;
  assign occupancy_o    = oocc_q;

  `PEIA_ASSERT_IMP(a_pause_time, clk_i, rst_ni, out_valid_q && send_q, (ptime_q == (opaused_q ? PAUSE_QUANTA : RESUME_QUANTA)))
  `PEIA_ASSERT_NXT(a_mark_arrival, clk_i, rst_ni, cmd_i.finish && (mode_q == MODE_ARRIVAL), !mark_q)
  `PEIA_ASSERT_NXT(a_ovf_departure, clk_i, rst_ni, cmd_i.finish && (mode_q == MODE_DEPARTURE), !ovf_q)
  `PEIA_ASSERT_NXT(a_paused_hold, clk_i, rst_ni, !cmd_i.finish, $stable(paused_q))

endmodule

`default_nettype wire
